[rtl/pal_pkg.sv]
package pal_pkg;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_GET    = 2'd2;

   // Status codes returned with every result word.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Request word.
   typedef struct packed {
      logic [1:0]         func;
      logic [4:0]         position;
      logic signed [31:0] value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [4:0]         count;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic               ins;
      logic               del;
      logic signed [31:0] value;
   } cell_ctrl_type;

endpackage

[rtl/pal_chan_if.sv]
interface pal_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/positional_array_list.sv]
// Ordered list of up to DEPTH signed 32-bit words addressed by 1-based position.
// Each list place is a register cell; insert and delete shift all cells at once,
// so a new request word is accepted in every cycle in which the response
// register is empty or being drained. The response word is registered and
// appears in the cycle after its request is accepted. No clearing pass follows
// reset: only the entry count and the response valid flag are cleared.
module positional_array_list
   import pal_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic reset,
   pal_chan_if.sink   req_chan,
   pal_chan_if.source rsp_chan
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               accept;
   req_type            req;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   pos_m1;
   logic [IDX_W-1:0]   pos_idx;
   logic               ins_pos_ok;
   logic               acc_pos_ok;
   logic               is_full;
   cell_ctrl_type      ctrl;
   logic [1:0]         status;
   logic signed [31:0] read_word;
   logic signed [31:0] cell_data [DEPTH];

   // Handshake: take a request whenever the response register can be refilled.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req            = req_chan.data;

   // Position checks against the current count.
   assign pos_ext    = CMP_W'(req.position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign pos_idx    = pos_m1[IDX_W-1:0];
   assign ins_pos_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign acc_pos_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= cnt_ext);
   assign is_full    = (cnt_ext == CMP_W'(DEPTH));

   // Decode the operation into a cell command, status, read word and new count.
   always_comb begin
      ctrl.ins   = 1'b0;
      ctrl.del   = 1'b0;
      ctrl.value = req.value;
      status     = STAT_OK;
      read_word  = '0;
      count_in   = count_ff;
      case (req.func)
         FUNC_INSERT: begin
            if (!ins_pos_ok) begin
               status = STAT_RANGE;
            end else if (is_full) begin
               status = STAT_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_DELETE: begin
            if (!acc_pos_ok) begin
               status = STAT_RANGE;
            end else begin
               ctrl.del = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         FUNC_GET: begin
            if (!acc_pos_ok) begin
               status = STAT_RANGE;
            end else begin
               read_word = cell_data[pos_idx];
            end
         end
         default: begin
            status = STAT_RANGE;
         end
      endcase
   end

   // Row of cells; each one hands its word to both neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_word;
      logic signed [31:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = ctrl.value;
      end else begin : g_left
         assign left_word = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_data[i];
      end else begin : g_right
         assign right_word = cell_data[i+1];
      end

      pal_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos_idx    (pos_idx),
         .left_data  (left_word),
         .right_data (right_word),
         .entry_out  (cell_data[i])
      );
   end

   // Next response register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = status;
         rsp_data_in.read_value = read_word;
         rsp_data_in.count      = 5'(CMP_W'(count_in));
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

[rtl/pal_cell.sv]
module pal_cell
   import pal_pkg::*;
#(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [IDX_W-1:0]    pos_idx,
   input  logic signed [31:0]  left_data,
   input  logic signed [31:0]  right_data,
   output logic signed [31:0]  entry_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   // Insert takes the new word at the target place and the left neighbor after it;
   // delete takes the right neighbor from the target place onward.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && (MY_IDX >= pos_idx)) begin
         entry_in = (MY_IDX == pos_idx) ? ctrl.value : left_data;
      end else if (ctrl.del && (MY_IDX >= pos_idx)) begin
         entry_in = right_data;
      end
   end

   // The entry itself needs no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule
